// ===== src/rrsp_pkg.sv =====
// Package for the RESP2 reply stream parser.
// Holds event codes, character constants and the result record type.
// No dependencies.
package rrsp_pkg;

    localparam int unsigned LimitW = 21;
    localparam logic [LimitW-1:0] LIMIT_RESET = 21'd1048576;  // 1024 * 1024

    // result event codes
    localparam logic [2:0] EV_OK        = 3'd0;
    localparam logic [2:0] EV_ERROR     = 3'd1;
    localparam logic [2:0] EV_INTEGER   = 3'd2;
    localparam logic [2:0] EV_BULK_BYTE = 3'd3;
    localparam logic [2:0] EV_BULK_END  = 3'd4;
    localparam logic [2:0] EV_NULL_BULK = 3'd5;
    localparam logic [2:0] EV_COUNT     = 3'd6;
    localparam logic [2:0] EV_FATAL     = 3'd7;

    // protocol characters
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [2:0]         event_res;
        logic signed [63:0] number;
        logic [7:0]         data_byte;
        logic               reply_done;
    } result_t;

endpackage

// ===== src/rrsp_rx_if.sv =====
// Byte input channel of the reply parser: valid/ready plus one reply byte.
// Depends on rrsp_pkg.
interface rrsp_rx_if
    import rrsp_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/rrsp_ev_if.sv =====
// Event output channel of the reply parser: valid/ready plus the result fields.
// Depends on rrsp_pkg.
interface rrsp_ev_if
    import rrsp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic signed [63:0] number;
    logic [7:0]         data_byte;
    logic               reply_done;

    modport source (output valid, output event_res, output number, output data_byte,
                    output reply_done, input ready);
    modport sink (input valid, input event_res, input number, input data_byte,
                  input reply_done, output ready);
endinterface

// ===== src/rrsp_parse_core.sv =====
// Parse state and per-byte next-state logic of the reply parser.
// One byte is consumed per step; at most one result comes out. Depends on rrsp_pkg.
module rrsp_parse_core
    import rrsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic [LimitW-1:0] line_limit,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_PRE  = 3'd1;
    localparam logic [2:0] PH_NUM  = 3'd2;
    localparam logic [2:0] PH_BULK = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;

    localparam logic [63:0] MAG_SAT  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_DIV10 = MAG_SAT / 64'd10;

    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        held_reg, held_next;
    logic              neg_reg, neg_next;
    logic              stopped_reg, stopped_next;
    logic [63:0]       acc_reg, acc_next;
    logic [LimitW-1:0] len_reg, len_next;
    logic [31:0]       items_reg, items_next;
    logic [31:0]       bulk_reg, bulk_next;
    logic              top_reg, top_next;
    logic [1:0]        skip_reg, skip_next;

    // derived values
    logic              held_digit, held_space, held_sign;
    logic [63:0]       acc_x10, acc_dig;
    logic [32:0]       mag32;
    logic signed [31:0] cnt;
    logic              cnt_pos;
    logic [63:0]       val64;
    logic [31:0]       items_dec, items_add, items_fin;
    logic [32:0]       items_sum;
    logic [31:0]       bulk_dec;
    logic [1:0]        skip_dec;
    logic [LimitW-1:0] len_inc;
    logic              fatal;

    assign held_digit = (held_reg >= CH_ZERO) && (held_reg <= CH_NINE);
    assign held_space = (held_reg == CH_SPACE) || ((held_reg >= CH_TAB) && (held_reg <= CH_CR));
    assign held_sign  = (held_reg == CH_PLUS) || (held_reg == CH_MINUS);

    // times ten plus digit, saturating at 2^63
    assign acc_x10 = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                   + {60'd0, 4'(held_reg - CH_ZERO)};
    assign acc_dig = (acc_reg > MAG_DIV10) ? MAG_SAT
                   : ((acc_x10 > MAG_SAT) ? MAG_SAT : acc_x10);

    // int32-saturated count / length
    assign mag32 = (acc_reg > 64'h8000_0000) ? 33'h1_0000_0000 >> 1 : acc_reg[32:0];
    assign cnt   = neg_reg ? 32'(33'd0 - mag32)
                 : ((acc_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_reg[31:0]);
    assign cnt_pos = !cnt[31] && (cnt != 32'sd0);

    // int64-saturated integer
    assign val64 = neg_reg ? (64'd0 - acc_reg)
                 : ((acc_reg > MAG_SAT - 64'd1) ? MAG_SAT - 64'd1 : acc_reg);

    assign items_dec = (items_reg != 32'd0) ? items_reg - 32'd1 : 32'd0;
    assign items_sum = {1'b0, items_dec} + {1'b0, cnt};
    assign items_add = items_sum[32] ? 32'hFFFF_FFFF : items_sum[31:0];
    assign items_fin = ((type_reg == CH_STAR) && cnt_pos) ? items_add : items_dec;

    assign bulk_dec = (bulk_reg != 32'd0) ? bulk_reg - 32'd1 : 32'd0;
    assign skip_dec = (skip_reg != 2'd0) ? skip_reg - 2'd1 : 2'd0;
    assign len_inc  = len_reg + LimitW'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        held_next    = held_reg;
        neg_next     = neg_reg;
        stopped_next = stopped_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        items_next   = items_reg;
        bulk_next    = bulk_reg;
        top_next     = top_reg;
        skip_next    = skip_reg;
        res_valid    = 1'b0;
        res          = '0;
        fatal        = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_BULK)
            begin
                bulk_next = bulk_dec;
                if (bulk_dec == 32'd0)
                begin
                    phase_next = PH_SKIP;
                    skip_next  = 2'd2;
                end
                res_valid     = 1'b1;
                res.event_res = EV_BULK_BYTE;
                res.data_byte = byte_in;
            end
            else if (phase_reg == PH_SKIP)
            begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0)
                begin
                    phase_next     = PH_TYPE;
                    res_valid      = 1'b1;
                    res.event_res  = EV_BULK_END;
                    res.reply_done = top_reg || (items_reg == 32'd0);
                    if (top_reg || (items_reg == 32'd0))
                        top_next = 1'b1;
                end
            end
            else if (byte_in == CH_LF)
            begin
                if (len_reg < LimitW'(2))
                    fatal = 1'b1;
                else
                begin
                    phase_next = PH_TYPE;
                    len_next   = '0;
                    if (top_reg)
                    begin
                        unique case (type_reg)
                            CH_MINUS:
                            begin
                                res_valid      = 1'b1;
                                res.event_res  = EV_ERROR;
                                res.reply_done = 1'b1;
                            end
                            CH_PLUS:
                            begin
                                res_valid      = 1'b1;
                                res.event_res  = EV_OK;
                                res.reply_done = 1'b1;
                            end
                            CH_COLON:
                            begin
                                res_valid      = 1'b1;
                                res.event_res  = EV_INTEGER;
                                res.number     = val64;
                                res.reply_done = 1'b1;
                            end
                            CH_DOLLAR:
                            begin
                                if (cnt[31])
                                begin
                                    res_valid      = 1'b1;
                                    res.event_res  = EV_NULL_BULK;
                                    res.reply_done = 1'b1;
                                end
                                else if (cnt_pos)
                                begin
                                    phase_next = PH_BULK;
                                    bulk_next  = cnt;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                    skip_next  = 2'd2;
                                end
                            end
                            CH_STAR:
                            begin
                                res_valid      = 1'b1;
                                res.event_res  = EV_COUNT;
                                res.number     = {{32{cnt[31]}}, cnt};
                                res.reply_done = !cnt_pos;
                                if (cnt_pos)
                                begin
                                    items_next = cnt;
                                    top_next   = 1'b0;
                                end
                            end
                            default: fatal = 1'b1;
                        endcase
                    end
                    else
                    begin
                        items_next = items_fin;
                        unique case (type_reg)
                            CH_STAR:
                            begin
                                res_valid     = 1'b1;
                                res.event_res = EV_COUNT;
                                res.number    = {{32{cnt[31]}}, cnt};
                            end
                            CH_COLON:
                            begin
                                res_valid     = 1'b1;
                                res.event_res = EV_INTEGER;
                                res.number    = val64;
                            end
                            CH_PLUS:
                            begin
                                res_valid     = 1'b1;
                                res.event_res = EV_OK;
                            end
                            CH_DOLLAR:
                            begin
                                if (cnt[31])
                                begin
                                    res_valid     = 1'b1;
                                    res.event_res = EV_NULL_BULK;
                                end
                                else if (cnt_pos)
                                begin
                                    phase_next = PH_BULK;
                                    bulk_next  = cnt;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                    skip_next  = 2'd2;
                                end
                            end
                            default: fatal = 1'b1;
                        endcase
                        // element finished: reply ends when nothing is pending
                        if (res_valid && (items_fin == 32'd0))
                        begin
                            res.reply_done = 1'b1;
                            top_next       = 1'b1;
                        end
                    end
                end
            end
            else if (len_inc >= line_limit)
                fatal = 1'b1;
            else
            begin
                if (len_reg == '0)
                begin
                    type_next    = byte_in;
                    neg_next     = 1'b0;
                    stopped_next = 1'b0;
                    acc_next     = '0;
                    phase_next   = PH_PRE;
                end
                else
                begin
                    // held byte is now known not to precede LF
                    if (len_reg >= LimitW'(2))
                    begin
                        if (phase_reg == PH_PRE)
                        begin
                            if (!held_space)
                            begin
                                phase_next = PH_NUM;
                                if (held_sign)
                                    neg_next = (held_reg == CH_MINUS);
                                else if (held_digit)
                                    acc_next = acc_dig;
                                else
                                    stopped_next = 1'b1;
                            end
                        end
                        else if (!stopped_reg)
                        begin
                            if (held_digit)
                                acc_next = acc_dig;
                            else
                                stopped_next = 1'b1;
                        end
                    end
                    held_next = byte_in;
                end
                len_next = len_inc;
            end

            if (fatal)
            begin
                phase_next   = PH_TYPE;
                type_next    = '0;
                held_next    = '0;
                neg_next     = 1'b0;
                stopped_next = 1'b0;
                acc_next     = '0;
                len_next     = '0;
                items_next   = '0;
                bulk_next    = '0;
                top_next     = 1'b1;
                skip_next    = '0;
                res_valid    = 1'b1;
                res          = '0;
                res.event_res  = EV_FATAL;
                res.reply_done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            type_reg    <= '0;
            held_reg    <= '0;
            neg_reg     <= 1'b0;
            stopped_reg <= 1'b0;
            acc_reg     <= '0;
            len_reg     <= '0;
            items_reg   <= '0;
            bulk_reg    <= '0;
            top_reg     <= 1'b1;
            skip_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            held_reg    <= held_next;
            neg_reg     <= neg_next;
            stopped_reg <= stopped_next;
            acc_reg     <= acc_next;
            len_reg     <= len_next;
            items_reg   <= items_next;
            bulk_reg    <= bulk_next;
            top_reg     <= top_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

// ===== src/resp_reply_stream_parser.sv =====
// Top level of the RESP2 reply stream parser.
// Depends on rrsp_pkg, rrsp_rx_if, rrsp_ev_if and rrsp_parse_core.
//
// Usage:
//   rx_in  : one reply byte per transfer (valid/ready, accepted when both high).
//   ev_out : zero or one event per input byte: status, error, integer, bulk
//            byte, bulk end, null bulk, array count or fatal; reply_done marks
//            the last event of a reply.
//   cfg_wr_en / cfg_wr_data : write line_limit (header line length incl. LF);
//            write only while the parser is idle.
// Pipeline: each event passes the input register, then the result register.
// Throughput: one byte per cycle, sustained while ev_out takes its events; the
//   per-byte parse update is a single pass of logic (times-ten add and
//   saturate on the 64-bit magnitude).
// Reset: parse state returns to "expect type byte", line_limit to 1048576,
//   both channel registers empty.
// Stall: when ev_out holds an event that is not taken, the input register
//   holds its byte and rx_in.ready drops; no byte or event is lost.
module resp_reply_stream_parser
    import rrsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [LimitW-1:0] cfg_wr_data,
    rrsp_rx_if.sink           rx_in,
    rrsp_ev_if.source         ev_out
);

    logic [LimitW-1:0] limit_reg;
    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              out_valid_reg;
    result_t           res_reg;

    logic              advance;
    logic              core_valid;
    result_t           core_res;

    // input register moves into the core when the result slot is free or draining
    assign advance     = in_valid_reg && (!out_valid_reg || ev_out.ready);
    assign rx_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_in.ready)
            in_valid_reg <= rx_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_in.valid && rx_in.ready)
            byte_reg <= rx_in.rx_byte;
    end

    rrsp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .byte_in    (byte_reg),
        .line_limit (limit_reg),
        .res_valid  (core_valid),
        .res        (core_res)
    );

    // result register; bytes that make no event simply drain the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= core_valid;
        else if (ev_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_valid)
            res_reg <= core_res;
    end

    assign ev_out.valid      = out_valid_reg;
    assign ev_out.event_res  = res_reg.event_res;
    assign ev_out.number     = res_reg.number;
    assign ev_out.data_byte  = res_reg.data_byte;
    assign ev_out.reply_done = res_reg.reply_done;

    // a fatal event always closes the reply
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_out.valid && (ev_out.event_res == EV_FATAL) |-> ev_out.reply_done)
        else $error("fatal event without reply_done");

    // number is only carried by integer and count events
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_out.valid && (ev_out.event_res != EV_INTEGER) && (ev_out.event_res != EV_COUNT)
        |-> (ev_out.number == 64'sd0))
        else $error("nonzero number on event without a number");

    // a payload byte never ends a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_out.valid && (ev_out.event_res == EV_BULK_BYTE) |-> !ev_out.reply_done)
        else $error("bulk byte marked as reply end");

    // input side only stalls behind a held, untaken event
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx_in.ready |-> (ev_out.valid && !ev_out.ready))
        else $error("input stalled without output backpressure");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for resp_reply_stream_parser: reply byte streams in,
// events checked against a scoreboard that carries its own parse model.
// Depends on rrsp_pkg, rrsp_rx_if, rrsp_ev_if and the parser RTL.
module tb;
    import rrsp_pkg::*;

    localparam int IDLE_LIMIT   = 1000;   // cycles without any transfer
    localparam int SETTLE_CYCLES = 4;     // covers the two-stage pipe
    localparam int DRAIN_CYCLES = 8;
    localparam bit [63:0] MAG_SAT = 64'h8000_0000_0000_0000;
    localparam logic [LimitW-1:0] LIMIT_MIN = 21'd3;
    localparam logic [LimitW-1:0] LIMIT_MAX = 21'd1048576;

    typedef enum logic [2:0] {PH_TYPE, PH_PRE, PH_NUM, PH_BULK, PH_SKIP} parse_phase_t;

    // Scoreboard: parse model plus the queue of events it predicts.
    class reply_scoreboard;
        bit [LimitW-1:0] line_limit;
        parse_phase_t    phase;
        bit [7:0]        type_ch;
        bit [7:0]        held;        // last header byte, dropped if LF follows
        bit              neg;
        bit              stopped;     // digit run ended
        bit              top;         // not inside an array
        bit [63:0]       mag;         // magnitude, saturates at 2^63
        bit [31:0]       line_len;
        bit [31:0]       items_left;
        bit [31:0]       bulk_left;
        int              skip_left;
        result_t         pending_events[$];
        int              errors;

        function new();
            line_limit = LIMIT_RESET;
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase = PH_TYPE;
            type_ch = 8'h00;
            held = 8'h00;
            neg = 1'b0;
            stopped = 1'b0;
            mag = '0;
            line_len = '0;
            items_left = '0;
            bulk_left = '0;
            top = 1'b1;
            skip_left = 0;
        endfunction

        function void push_event(logic [2:0] ev, logic [63:0] num, logic [7:0] data, bit done);
            result_t r;
            r.event_res = ev;
            r.number = num;
            r.data_byte = data;
            r.reply_done = done;
            pending_events.insert(pending_events.size(), r);
        endfunction

        function void fatal_event();
            clear_state();
            push_event(EV_FATAL, '0, '0, 1'b1);
        endfunction

        // element events close the reply once nothing is pending
        function void element_event(logic [2:0] ev, logic [63:0] num);
            bit done;
            done = (items_left == 0);
            if (done)
                top = 1'b1;
            push_event(ev, num, '0, done);
        endfunction

        function void add_digit(bit [7:0] c);
            if (mag > MAG_SAT / 10) begin
                mag = MAG_SAT;
            end
            else begin
                mag = mag * 10 + (c - CH_ZERO);
                if (mag > MAG_SAT)
                    mag = MAG_SAT;
            end
        endfunction

        function void start_bulk(logic signed [63:0] len);
            if (len > 0) begin
                phase = PH_BULK;
                bulk_left = len[31:0];
            end
            else begin
                phase = PH_SKIP;
                skip_left = 2;
            end
        endfunction

        function void set_limit(logic [LimitW-1:0] limit);
            line_limit = limit;
        endfunction

        // one accepted byte in, zero or one predicted event out
        function void note_byte(bit [7:0] b);
            bit [31:0]         n;
            bit [63:0]         m32;
            bit [63:0]         v64;
            logic signed [63:0] cnt;
            bit [32:0]         sum;
            bit [7:0]          c;
            bit                digit;

            if (phase == PH_BULK) begin
                if (bulk_left > 0)
                    bulk_left--;
                if (bulk_left == 0) begin
                    phase = PH_SKIP;
                    skip_left = 2;
                end
                push_event(EV_BULK_BYTE, '0, b, 1'b0);
                return;
            end
            if (phase == PH_SKIP) begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left != 0)
                    return;
                phase = PH_TYPE;
                if (top || items_left == 0) begin
                    top = 1'b1;
                    push_event(EV_BULK_END, '0, '0, 1'b1);
                end
                else begin
                    push_event(EV_BULK_END, '0, '0, 1'b0);
                end
                return;
            end

            // header line
            if (b == CH_LF) begin
                if (line_len < 2) begin
                    fatal_event();
                    return;
                end
                // 32-bit view for counts/lengths, 64-bit view for integers
                if (neg)
                    m32 = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
                else
                    m32 = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
                cnt = neg ? -$signed(m32) : $signed(m32);
                if (neg)
                    v64 = 64'd0 - mag;
                else
                    v64 = (mag > MAG_SAT - 1) ? MAG_SAT - 1 : mag;
                phase = PH_TYPE;
                line_len = '0;
                if (top) begin
                    case (type_ch)
                        CH_MINUS: push_event(EV_ERROR, '0, '0, 1'b1);
                        CH_PLUS:  push_event(EV_OK, '0, '0, 1'b1);
                        CH_COLON: push_event(EV_INTEGER, v64, '0, 1'b1);
                        CH_DOLLAR:
                        begin
                            if (cnt < 0)
                                push_event(EV_NULL_BULK, '0, '0, 1'b1);
                            else
                                start_bulk(cnt);
                        end
                        CH_STAR:
                        begin
                            if (cnt >= 1) begin
                                items_left = cnt[31:0];
                                top = 1'b0;
                                push_event(EV_COUNT, cnt, '0, 1'b0);
                            end
                            else begin
                                push_event(EV_COUNT, cnt, '0, 1'b1);
                            end
                        end
                        default: fatal_event();
                    endcase
                    return;
                end
                if (items_left > 0)
                    items_left--;
                case (type_ch)
                    CH_STAR:
                    begin
                        if (cnt >= 1) begin
                            sum = {1'b0, items_left} + {1'b0, cnt[31:0]};
                            items_left = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        end
                        element_event(EV_COUNT, cnt);
                    end
                    CH_COLON: element_event(EV_INTEGER, v64);
                    CH_PLUS:  element_event(EV_OK, '0);
                    CH_DOLLAR:
                    begin
                        if (cnt < 0)
                            element_event(EV_NULL_BULK, '0);
                        else
                            start_bulk(cnt);
                    end
                    default: fatal_event();
                endcase
                return;
            end

            n = line_len + 1;
            if (n >= line_limit) begin
                fatal_event();
                return;
            end
            if (line_len == 0) begin
                type_ch = b;
                neg = 1'b0;
                stopped = 1'b0;
                mag = '0;
                phase = PH_PRE;
            end
            else begin
                // the held byte is now known not to be the one before LF
                if (line_len >= 2) begin
                    c = held;
                    digit = (c >= CH_ZERO && c <= CH_NINE);
                    if (phase == PH_PRE) begin
                        if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                            phase = PH_NUM;
                            if (c == CH_PLUS || c == CH_MINUS)
                                neg = (c == CH_MINUS);
                            else if (digit)
                                add_digit(c);
                            else
                                stopped = 1'b1;
                        end
                    end
                    else if (!stopped) begin
                        if (digit)
                            add_digit(c);
                        else
                            stopped = 1'b1;
                    end
                end
                held = b;
            end
            line_len = n;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_event(logic [2:0] ev, logic [63:0] num, logic [7:0] data,
                                  logic done);
            result_t want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event, expected none, actual ev %0d num %h data %h done %b",
                         $time, ev, num, data, done);
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_res", 64'(want.event_res), 64'(ev));
            compare_field("number", want.number, num);
            compare_field("data_byte", 64'(want.data_byte), 64'(data));
            compare_field("reply_done", 64'(want.reply_done), 64'(done));
        endfunction
    endclass

    bit                clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [LimitW-1:0] cfg_wr_data;

    rrsp_rx_if rx_if();
    rrsp_ev_if ev_if();

    resp_reply_stream_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_in       (rx_if),
        .ev_out      (ev_if)
    );

    reply_scoreboard sb;
    bit              quiet;        // no gaps and no stalls while set
    int              stall_left;
    logic [7:0]      stream_q[$];  // reply bytes waiting to be sent

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Stream building
    // ---------------------------------------------------------------
    function automatic void put(logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    // fixed CR LF ending
    function automatic void put_line(logic [7:0] kind, string body);
        put(kind);
        put_text(body);
        put(CH_CR);
        put(CH_LF);
    endfunction

    // byte before LF is dropped by the parser, so it need not be CR
    function automatic void close_line();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF)
            b = CH_CR;
        put(($urandom_range(0, 9) == 0) ? b : CH_CR);
        put(CH_LF);
    endfunction

    // leading white space and sign; minus only where asked for
    function automatic string pad_text(bit signs);
        int r;
        r = $urandom_range(0, 11);
        if (!signs && (r == 2 || r == 3 || r == 4 || r == 7))
            r = 11;
        case (r)
            0: return " ";
            1: return "\t";
            2: return " \t-";
            3, 4: return "-";
            5: return "+";
            6: return " +";
            7: return "+-";   // second sign stops the digit run
            default: return "";
        endcase
    endfunction

    // integer body: small, 32/64-bit, boundary, overlong or empty
    function automatic string int_text();
        string     s;
        bit [63:0] m;
        s = pad_text(1'b1);
        case ($urandom_range(0, 5))
            0: s = {s, $sformatf("%0d", $urandom_range(0, 99))};
            1:
            begin
                m = 64'($urandom());
                s = {s, $sformatf("%0d", m)};
            end
            2:
            begin
                m = {$urandom(), $urandom()};
                s = {s, $sformatf("%0d", m)};
            end
            3:
            begin
                case ($urandom_range(0, 7))
                    0: m = 64'd2147483647;
                    1: m = 64'd2147483648;
                    2: m = 64'd4294967295;
                    3: m = 64'h7FFF_FFFF_FFFF_FFFF;
                    4: m = MAG_SAT;
                    5: m = '1;
                    6: m = 64'd922337203685477580;
                    default: m = 64'd922337203685477581;
                endcase
                s = {s, $sformatf("%0d", m)};
            end
            4: repeat ($urandom_range(19, 26)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            default: ;  // no digits at all
        endcase
        if ($urandom_range(0, 6) == 0)
            s = {s, $sformatf("x%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic void put_status_text();
        repeat ($urandom_range(0, 6)) put(8'($urandom_range(CH_SPACE, 8'h7E)));
    endfunction

    // One value; arrays recurse so the flattened count matches.
    function automatic void gen_value(int depth, bit element);
        int kind;
        int n;
        int len;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            put(CH_PLUS);
            put_status_text();
            close_line();
        end
        else if (kind < 25 && (!element || $urandom_range(0, 9) == 0)) begin
            // an error reply as an element is a bad element type
            put(CH_MINUS);
            put_status_text();
            close_line();
        end
        else if (kind < 45) begin
            put(CH_COLON);
            put_text(int_text());
            close_line();
        end
        else if (kind < 65) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            put(CH_DOLLAR);
            put_text({pad_text(1'b0), $sformatf("%0d", len)});
            close_line();
            repeat (len) put(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 6) == 0) begin
                // trailer is skipped unchecked
                put(8'($urandom_range(0, 255)));
                put(8'($urandom_range(0, 255)));
            end
            else begin
                put(CH_CR);
                put(CH_LF);
            end
        end
        else if (kind < 72) begin
            put(CH_DOLLAR);
            put_text({pad_text(1'b0), "-", $sformatf("%0d", $urandom_range(1, 3))});
            close_line();
        end
        else if (depth < 3) begin
            n = $urandom_range(0, (depth == 0) ? 4 : 2);
            put(CH_STAR);
            r = $urandom_range(0, 39);
            if (r < 2) begin
                put_text("-1");
                n = 0;
            end
            else if (r == 2) begin
                // odd count, elements follow as later replies
                put_text(int_text());
                n = 0;
            end
            else begin
                put_text({pad_text(1'b0), $sformatf("%0d", n)});
            end
            close_line();
            for (int i = 0; i < n; i++)
                gen_value(depth + 1, 1'b1);
        end
        else begin
            put(CH_PLUS);
            close_line();
        end
    endfunction

    // One reply: mostly well formed, some noise, corners and cut-off replies.
    function automatic void gen_reply();
        int r;
        int start;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                    put(CH_LF);
            end
            else begin
                // random type byte, mostly unknown
                put(8'($urandom_range(0, 255)));
                put_text(int_text());
                close_line();
            end
        end
        else if (r < 8) begin
            case ($urandom_range(0, 2))
                0:
                begin
                    // pending element count saturates, bad element type clears it
                    repeat (3) put_line(CH_STAR, "2147483647");
                    put_line(CH_MINUS, "");
                end
                1: put_line(CH_COLON, "-9223372036854775808");
                default:
                begin
                    // LF as the second byte of a line
                    put(CH_PLUS);
                    put(CH_LF);
                end
            endcase
        end
        else begin
            start = stream_q.size();
            gen_value(0, 1'b0);
            if (r < 13 && stream_q.size() > start + 1)
                repeat ($urandom_range(1, stream_q.size() - start - 1))
                    stream_q.delete(stream_q.size() - 1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Entered at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so the next call either keeps it or drops it once.
    task automatic push_byte(logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            push_byte(stream_q.pop_front());
    endtask

    // Register write with the parser idle: all events in, then the pipe settles
    // in case the last byte gave no event.
    task automatic write_limit(logic [LimitW-1:0] limit);
        rx_if.valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(limit);
    endtask

    task automatic run_phase(logic [LimitW-1:0] limit, int budget, bit calm);
        int sent;
        sent = 0;
        write_limit(limit);
        while (sent < budget) begin
            quiet = calm || ($urandom_range(0, 9) == 0);
            gen_reply();
            sent += stream_q.size();
            send_stream();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        quiet = 1'b0;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every reply type, short line, unknown types
        write_limit(LIMIT_MAX);
        put(CH_LF);                     // LF as first byte
        put_line(CH_PLUS, "");
        put_line(CH_MINUS, "");
        put_line(CH_COLON, "-7");
        put_line(CH_DOLLAR, "0");       // empty bulk
        put(CH_CR);
        put(CH_LF);
        put_line(CH_DOLLAR, "-1");
        put_line(CH_STAR, "1");
        put_line(CH_DOLLAR, "1");
        put_text("Z");
        put(CH_CR);
        put(CH_LF);
        put_line(CH_STAR, "1");
        put_line(CH_MINUS, "");         // bad element type
        put_line(8'h3F, "");            // unknown top-level type
        send_stream();

        // random phases over several line limits, shortest and longest included
        run_phase(LIMIT_MAX, 300, 1'b0);
        run_phase(LIMIT_MIN, 150, 1'b0);
        run_phase(21'd6, 200, 1'b1);
        run_phase(LimitW'($urandom_range(8, 40)), 300, 1'b0);
        run_phase(21'd14, 250, 1'b0);
        run_phase(LIMIT_MAX, 450, 1'b0);

        rx_if.valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Event sink: ready drops for random stalls, none while quiet.
    initial begin
        ev_if.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                ev_if.ready <= 1'b0;
                stall_left--;
            end
            else begin
                ev_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Every event transfer is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && ev_if.valid && ev_if.ready)
            sb.check_event(ev_if.event_res, ev_if.number, ev_if.data_byte, ev_if.reply_done);
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    initial begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/rrsp_pkg.sv
src/rrsp_rx_if.sv
src/rrsp_ev_if.sv
src/rrsp_parse_core.sv
src/resp_reply_stream_parser.sv
dv/tb.sv
